>>> sv/adcb_pkg.sv
package adcb_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_SHIFT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_RATE_SHIFT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PKT_SAMPLES = 8'd3;

	// register reset values
	localparam logic [4:0] RST_INPUT_SHIFT = 5'd15;
	localparam logic [3:0] RST_DC_RATE_SHIFT = 4'd6;
	localparam logic [3:0] RST_GAIN_SHIFT = 4'd5;
	localparam logic [9:0] RST_PKT_SAMPLES = 10'd320;

	// sync pattern
	localparam logic [7:0] SYNC_A = 8'hA5;
	localparam logic [7:0] SYNC_B = 8'h5A;

	// saturation limits
	localparam logic signed [31:0] WIDE_MAX = 32'sd131071;
	localparam logic signed [31:0] WIDE_MIN = -32'sd131072;
	localparam logic [15:0] PCM_MAX = 16'h7FFF;
	localparam logic [15:0] PCM_MIN = 16'h8000;

	// byte slots of one job, header first
	localparam logic [2:0] BYTE_SYNC_A = 3'd0;
	localparam logic [2:0] BYTE_SYNC_B = 3'd1;
	localparam logic [2:0] BYTE_CNT_LO = 3'd2;
	localparam logic [2:0] BYTE_CNT_HI = 3'd3;
	localparam logic [2:0] BYTE_LEN_LO = 3'd4;
	localparam logic [2:0] BYTE_LEN_HI = 3'd5;
	localparam logic [2:0] BYTE_PCM_LO = 3'd6;
	localparam logic [2:0] BYTE_PCM_HI = 3'd7;

	typedef struct packed {
		logic [4:0] input_shift;
		logic [3:0] dc_rate_shift;
		logic [3:0] gain_shift;
		logic [9:0] pkt_samples;
	} cfg_t;

	typedef struct packed {
		logic        hdr;
		logic        last;
		logic [15:0] count;
		logic [10:0] len;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [15:0] pcm;
	} job_t;

endpackage

>>> sv/adcb_front.sv
module adcb_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adcb_pkg::cfg_t        cfg,
	input  logic                  push,
	output logic                  full,
	input  logic signed [31:0]    raw_sample,
	output logic                  job_valid,
	input  logic                  job_ready,
	output adcb_pkg::job_t        job
);

	logic adv;
	logic accept;
	logic [9:0] frame;
	logic [9:0] pos_q;
	logic [15:0] pkt_q;
	adcb_pkg::meta_t meta_in;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] raw_s1;
	logic signed [17:0] s_s2, s_s3;
	logic signed [17:0] dcn_s3;
	logic signed [17:0] dc_q;
	logic [15:0] pcm_s4;
	adcb_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4;

	logic signed [31:0] shifted;
	logic signed [17:0] s_sat;
	logic signed [18:0] delta;
	logic signed [18:0] step;
	logic signed [17:0] dc_next;
	logic signed [18:0] diff;
	logic signed [33:0] yw;
	logic [15:0] pcm_sat;

	assign adv = !(v_s4 && !job_ready);
	assign full = !adv;
	assign accept = push && adv;
	assign job_valid = v_s4;
	assign job = '{meta: meta_s4, pcm: pcm_s4};

	// framing classification at the door
	assign frame = (cfg.pkt_samples == 10'd0) ? 10'd1 : cfg.pkt_samples;

	always_comb begin
		meta_in.hdr = (pos_q == 10'd0);
		meta_in.last = ({1'b0, pos_q} + 11'd1) >= {1'b0, frame};
		meta_in.count = pkt_q;
		meta_in.len = {frame, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pkt_q <= '0;
		end else if (accept) begin
			if (meta_in.hdr) begin
				pkt_q <= pkt_q + 16'd1;
			end
			if (meta_in.last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 10'd1;
			end
		end
	end

	// input shift and wide saturation
	always_comb begin
		shifted = raw_s1 >>> cfg.input_shift;
		if (shifted > adcb_pkg::WIDE_MAX) begin
			s_sat = 18'sh1FFFF;
		end else if (shifted < adcb_pkg::WIDE_MIN) begin
			s_sat = 18'sh20000;
		end else begin
			s_sat = shifted[17:0];
		end
	end

	// leaky tracker
	always_comb begin
		delta = {s_s2[17], s_s2} - {dc_q[17], dc_q};
		step = delta >>> cfg.dc_rate_shift;
		dc_next = dc_q + step[17:0];
	end

	// dc removal, gain, pcm saturation
	always_comb begin
		diff = {s_s3[17], s_s3} - {dcn_s3[17], dcn_s3};
		yw = {{15{diff[18]}}, diff} <<< cfg.gain_shift;
		if (!yw[33] && (yw[32:15] != '0)) begin
			pcm_sat = adcb_pkg::PCM_MAX;
		end else if (yw[33] && (yw[32:15] != '1)) begin
			pcm_sat = adcb_pkg::PCM_MIN;
		end else begin
			pcm_sat = yw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			dc_q <= '0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s2) begin
				dc_q <= dc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1 <= raw_sample;
			meta_s1 <= meta_in;
			s_s2 <= s_sat;
			meta_s2 <= meta_s1;
			s_s3 <= s_s2;
			dcn_s3 <= dc_next;
			meta_s3 <= meta_s2;
			pcm_s4 <= pcm_sat;
			meta_s4 <= meta_s3;
		end
	end

	a_dc_holds_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(dc_q))
		else $error("dc tracker moved while the pipeline was stalled");

endmodule

>>> sv/adcb_fifo.sv
module adcb_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  adcb_pkg::job_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output logic           not_empty,
	output adcb_pkg::job_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	adcb_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data = mem_q[rd_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("job queue count beyond depth");

endmodule

>>> sv/adcb_back.sv
module adcb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_pop,
	input  adcb_pkg::job_t job,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     data_byte,
	output logic           is_header,
	output logic           last_byte
);

	adcb_pkg::job_t cur_q;
	logic busy_q;
	logic [2:0] idx_q;
	logic ov_q;
	logic [7:0] data_q;
	logic hdr_q, last_q;

	logic out_free, load, at_end, take;
	logic [7:0] sel_data;
	logic sel_hdr, sel_last;

	assign out_free = !ov_q || pop;
	assign load = busy_q && out_free;
	assign at_end = (idx_q == adcb_pkg::BYTE_PCM_HI);
	assign take = job_valid && (!busy_q || (load && at_end));
	assign job_pop = take;

	assign empty = !ov_q;
	assign data_byte = data_q;
	assign is_header = hdr_q;
	assign last_byte = last_q;

	always_comb begin
		sel_hdr = 1'b1;
		sel_last = 1'b0;
		unique case (idx_q)
			adcb_pkg::BYTE_SYNC_A: sel_data = adcb_pkg::SYNC_A;
			adcb_pkg::BYTE_SYNC_B: sel_data = adcb_pkg::SYNC_B;
			adcb_pkg::BYTE_CNT_LO: sel_data = cur_q.meta.count[7:0];
			adcb_pkg::BYTE_CNT_HI: sel_data = cur_q.meta.count[15:8];
			adcb_pkg::BYTE_LEN_LO: sel_data = cur_q.meta.len[7:0];
			adcb_pkg::BYTE_LEN_HI: sel_data = {5'd0, cur_q.meta.len[10:8]};
			adcb_pkg::BYTE_PCM_LO: begin
				sel_data = cur_q.pcm[7:0];
				sel_hdr = 1'b0;
			end
			adcb_pkg::BYTE_PCM_HI: begin
				sel_data = cur_q.pcm[15:8];
				sel_hdr = 1'b0;
				sel_last = cur_q.meta.last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= adcb_pkg::BYTE_SYNC_A;
			ov_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q <= job.meta.hdr ? adcb_pkg::BYTE_SYNC_A : adcb_pkg::BYTE_PCM_LO;
			end else if (load && at_end) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
			end
			if (out_free) begin
				ov_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= job;
		end
		if (load) begin
			data_q <= sel_data;
			hdr_q <= sel_hdr;
			last_q <= sel_last;
		end
	end

	a_header_slots_need_header: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (idx_q != adcb_pkg::BYTE_PCM_LO) && (idx_q != adcb_pkg::BYTE_PCM_HI))
		|-> cur_q.meta.hdr)
		else $error("header byte slot reached on a job without header");

	a_last_not_header: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && last_q) |-> !hdr_q)
		else $error("end of packet flagged on a header byte");

endmodule

>>> sv/audio_dc_block_and_packet_framer.sv
// audio dc blocker and packet framer. each signed 32-bit raw sample is shifted right
// arithmetically by input_shift, clamped to 18 bits, run through a leaky dc tracker
// (dc += (s - dc) >> dc_rate_shift) whose new level is subtracted, then shifted left
// by gain_shift and saturated to 16 bits; the pcm word leaves as two bytes, low first.
// the first sample of every packet is preceded by a six-byte header: a5, 5a, the packet
// counter and the payload length (2 * pkt_samples, zero counts as one), both
// little-endian. a four-stage front pipeline takes one sample per cycle into a small
// job queue while that queue has room; the back end turns each job into bytes at one
// byte per cycle while the output keeps being popped, so a sample yields two bytes
// mid-packet and eight at the start of a packet.
// registers are written over the cfg channel (always ready) and must only change
// while the block is idle; unknown indexes are ignored.
module audio_dc_block_and_packet_framer #(
	parameter int JOB_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample side
	input  logic                              push,
	output logic                              full,
	input  logic signed [31:0]                raw_sample,
	// byte side
	output logic                              empty,
	input  logic                              pop,
	output logic [7:0]                        data_byte,
	output logic                              is_header,
	output logic                              last_byte,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [adcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [adcb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	adcb_pkg::cfg_t cfg_q;

	// jobs between front and back
	logic job_wr, job_full, job_avail, job_rd;
	adcb_pkg::job_t job_in, job_out;

	// register file: no wait states
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_shift <= adcb_pkg::RST_INPUT_SHIFT;
			cfg_q.dc_rate_shift <= adcb_pkg::RST_DC_RATE_SHIFT;
			cfg_q.gain_shift <= adcb_pkg::RST_GAIN_SHIFT;
			cfg_q.pkt_samples <= adcb_pkg::RST_PKT_SAMPLES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				adcb_pkg::REG_INPUT_SHIFT:   cfg_q.input_shift <= cfg_data[4:0];
				adcb_pkg::REG_DC_RATE_SHIFT: cfg_q.dc_rate_shift <= cfg_data[3:0];
				adcb_pkg::REG_GAIN_SHIFT:    cfg_q.gain_shift <= cfg_data[3:0];
				adcb_pkg::REG_PKT_SAMPLES:   cfg_q.pkt_samples <= cfg_data[9:0];
				default: begin
					// write to an unused index is dropped
				end
			endcase
		end
	end

	// front: framing decision, shift, dc tracker, gain and saturation
	adcb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.raw_sample (raw_sample),
		.job_valid  (job_wr),
		.job_ready  (!job_full),
		.job        (job_in)
	);

	// decouples the sample pipeline from the byte serializer
	adcb_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_wr),
		.wr_data   (job_in),
		.full      (job_full),
		.rd_en     (job_rd),
		.not_empty (job_avail),
		.rd_data   (job_out)
	);

	// back: one byte per beat into the output register
	adcb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_avail),
		.job_pop   (job_rd),
		.job       (job_out),
		.pop       (pop),
		.empty     (empty),
		.data_byte (data_byte),
		.is_header (is_header),
		.last_byte (last_byte)
	);

endmodule

>>> tb/audio_dc_block_and_packet_framer_tb.sv
`timescale 1ns / 1ps

module audio_dc_block_and_packet_framer_tb;

	// run shape
	localparam int RANDOM_SAMPLES = 430;
	localparam int SETTLE_CYCLES = 16;     // margin for the pipeline to empty after the last owed byte
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on any port
	localparam int REPORT_LIMIT = 10;
	localparam int MAX_GAP = 14;

	localparam int IDX_W = adcb_pkg::CFG_IDX_W;
	localparam int DATA_W = adcb_pkg::CFG_DATA_W;

	// an index that maps to no register
	localparam logic [IDX_W-1:0] REG_UNMAPPED = 8'hFF;

	// pcm saturation bounds as plain signed numbers
	localparam longint PCM_TOP = 32767;
	localparam longint PCM_BOTTOM = -32768;

	// one byte of the packet stream
	typedef struct packed {
		logic [7:0] data;
		logic       hdr;
		logic       last;
	} stream_byte_t;

	// directed stimulus: a register write or a sample, with an optional typed-in pcm word
	typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  data;
		logic [31:0]        raw;
		logic               pinned;
		logic [15:0]        pcm;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic signed [31:0]    raw_sample;
	logic                  empty;
	logic                  pop;
	logic [7:0]            data_byte;
	logic                  is_header;
	logic                  last_byte;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index;
	logic [DATA_W-1:0]     cfg_data;

	// pcm word typed into the table travels with the sample beat
	logic        pin_valid;
	logic [15:0] pin_pcm;

	// shadow copy of the block: registers and filter/framer state
	adcb_pkg::cfg_t shadow_cfg;
	longint         dc_track;
	logic [9:0]     slot_pos;
	logic [15:0]    pkt_count;

	// bytes still owed by the block, oldest first
	stream_byte_t pending_bytes[$];
	stream_byte_t want;

	// bookkeeping
	int  errors;
	int  samples_taken;
	int  table_samples;
	int  bytes_seen;
	int  packets_opened;
	int  writes_seen;
	int  settings_run;
	int  idle_cycles;
	bit  tx_steady;
	bit  rx_steady;
	bit  writes_open;
	row_t directed_rows[$];

	audio_dc_block_and_packet_framer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.raw_sample (raw_sample),
		.empty      (empty),
		.pop        (pop),
		.data_byte  (data_byte),
		.is_header  (is_header),
		.last_byte  (last_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// filter one sample and queue the bytes it produces; a typed-in word replaces the pcm bytes
	task automatic frame_sample(input logic [31:0] raw, input logic pinned,
		input logic [15:0] typed_pcm);
		longint      s;
		longint      y;
		logic [10:0] frame;
		logic [10:0] len;
		logic [15:0] pcm;
		logic        last;
		begin
			// a zero frame length behaves as one sample per packet
			frame = (shadow_cfg.pkt_samples == '0) ? 11'd1 : {1'b0, shadow_cfg.pkt_samples};

			// arithmetic shift is a floor shift, then clamp to 18 bits for the tracker
			s = longint'($signed(raw)) >>> shadow_cfg.input_shift;
			if (s > adcb_pkg::WIDE_MAX) s = adcb_pkg::WIDE_MAX;
			if (s < adcb_pkg::WIDE_MIN) s = adcb_pkg::WIDE_MIN;

			// leaky tracker; a zero rate shift copies the sample outright
			dc_track = dc_track + ((s - dc_track) >>> shadow_cfg.dc_rate_shift);

			// remove dc, apply gain, saturate to 16 bits
			y = (s - dc_track) <<< shadow_cfg.gain_shift;
			if (y > PCM_TOP) y = PCM_TOP;
			if (y < PCM_BOTTOM) y = PCM_BOTTOM;
			pcm = pinned ? typed_pcm : y[15:0];

			// header ahead of the first sample of a packet, counter taken then bumped
			if (slot_pos == '0) begin
				len = frame << 1;
				pending_bytes.push_back('{adcb_pkg::SYNC_A, 1'b1, 1'b0});
				pending_bytes.push_back('{adcb_pkg::SYNC_B, 1'b1, 1'b0});
				pending_bytes.push_back('{pkt_count[7:0], 1'b1, 1'b0});
				pending_bytes.push_back('{pkt_count[15:8], 1'b1, 1'b0});
				pending_bytes.push_back('{len[7:0], 1'b1, 1'b0});
				pending_bytes.push_back('{{5'd0, len[10:8]}, 1'b1, 1'b0});
				pkt_count = pkt_count + 16'd1;
				packets_opened++;
			end

			// a frame shortened mid-packet closes the packet on this sample
			last = ({1'b0, slot_pos} + 11'd1) >= frame;
			pending_bytes.push_back('{pcm[7:0], 1'b0, 1'b0});
			pending_bytes.push_back('{pcm[15:8], 1'b0, last});
			slot_pos = last ? 10'd0 : slot_pos + 10'd1;
		end
	endtask

	// monitor: register writes, accepted samples, then the byte side, all on the same edge
	always @(posedge clk) begin
		if (!arst_n) begin
			shadow_cfg.input_shift = adcb_pkg::RST_INPUT_SHIFT;
			shadow_cfg.dc_rate_shift = adcb_pkg::RST_DC_RATE_SHIFT;
			shadow_cfg.gain_shift = adcb_pkg::RST_GAIN_SHIFT;
			shadow_cfg.pkt_samples = adcb_pkg::RST_PKT_SAMPLES;
			dc_track = 0;
			slot_pos = '0;
			pkt_count = '0;
			pending_bytes.delete();
			idle_cycles = 0;
		end else begin
			// register write beat; unknown indexes change nothing
			if (cfg_valid && cfg_ready) begin
				writes_seen++;
				case (cfg_index)
					adcb_pkg::REG_INPUT_SHIFT: shadow_cfg.input_shift = cfg_data[4:0];
					adcb_pkg::REG_DC_RATE_SHIFT: shadow_cfg.dc_rate_shift = cfg_data[3:0];
					adcb_pkg::REG_GAIN_SHIFT: shadow_cfg.gain_shift = cfg_data[3:0];
					adcb_pkg::REG_PKT_SAMPLES: shadow_cfg.pkt_samples = cfg_data[9:0];
					default: ;
				endcase
			end

			// sample beat
			if (push && !full) begin
				samples_taken++;
				frame_sample(raw_sample, pin_valid, pin_pcm);
			end

			// byte beat against the oldest owed byte
			if (pop && !empty) begin
				bytes_seen++;
				if (pending_bytes.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("byte %0d: none expected, got data %02h hdr %0b last %0b",
							bytes_seen, data_byte, is_header, last_byte);
				end else begin
					want = pending_bytes.pop_front();
					if (data_byte !== want.data || is_header !== want.hdr ||
						last_byte !== want.last) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
								bytes_seen, want.data, want.hdr, want.last,
								data_byte, is_header, last_byte);
					end
				end
			end

			// watchdog on cycles where no port moves a beat
			if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d bytes still owed",
					idle_cycles, pending_bytes.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// byte side: random stall before every beat, none in steady stretches
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// one sample beat; push stays high into the next call so back-to-back beats keep it up
	task automatic send_sample(input logic [31:0] raw, input logic pinned,
		input logic [15:0] typed_pcm);
		int gap;
		begin
			gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (writes_open) begin
				cfg_valid <= 1'b0;
				writes_open = 1'b0;
			end
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			push <= 1'b1;
			raw_sample <= raw;
			pin_valid <= pinned;
			pin_pcm <= typed_pcm;
			do @(posedge clk); while (full);
		end
	endtask

	// one register write beat; valid stays up for the next write of a batch
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			writes_open = 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
	endtask

	// stop sending, let every owed byte drain, then give the pipeline time to empty
	task automatic settle_idle();
		begin
			push <= 1'b0;
			@(posedge clk);
			while (pending_bytes.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic add_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		directed_rows.push_back(row_t'{ROW_WRITE, idx, data, 32'h0, 1'b0, 16'h0});
	endtask

	task automatic add_sample(input logic [31:0] raw, input logic pinned, input logic [15:0] pcm);
		directed_rows.push_back(row_t'{ROW_SAMPLE, '0, '0, raw, pinned, pcm});
	endtask

	// register value with random junk above its width, which the block must drop
	function automatic logic [DATA_W-1:0] with_junk(input int value, input int width);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] junk;
		mask = (16'h1 << width) - 16'h1;
		junk = DATA_W'($urandom);
		return (junk & ~mask) | (DATA_W'(value) & mask);
	endfunction

	// raw sample mix: full-range noise, rails, scaled noise, and tone around a phase offset
	function automatic logic [31:0] pick_raw(input logic [31:0] offset, input int scale);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return $signed($urandom) >>> $urandom_range(0, 31);
			default: return offset + ((int'($urandom_range(0, 511)) - 256) <<< scale);
		endcase
	endfunction

	initial begin
		int          random_sent;
		int          phase_len;
		int          scale;
		logic [31:0] offset;

		arst_n = 1'b0;
		push = 1'b0;
		raw_sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pin_valid = 1'b0;
		pin_pcm = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		writes_open = 1'b0;
		errors = 0;
		samples_taken = 0;
		table_samples = 0;
		bytes_seen = 0;
		packets_opened = 0;
		writes_seen = 0;
		settings_run = 1;
		random_sent = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: silence, then both rails saturate the pcm word
		add_sample(32'h0000_0000, 1'b1, 16'h0000);
		add_sample(32'h7FFF_FFFF, 1'b1, 16'h7FFF);
		add_sample(32'h8000_0000, 1'b1, 16'h8000);
		add_sample(32'hFFFF_FFFF, 1'b0, 16'h0);
		// one sample per packet, tracker copying the sample: output is zero
		add_write(adcb_pkg::REG_PKT_SAMPLES, 16'd1);
		add_write(adcb_pkg::REG_DC_RATE_SHIFT, 16'd0);
		add_sample(32'h1234_5678, 1'b1, 16'h0000);
		// no input shift: the wide sample clamps to 18 bits, still copied exactly
		add_write(adcb_pkg::REG_INPUT_SHIFT, 16'd0);
		add_sample(32'h7FFF_FFFF, 1'b1, 16'h0000);
		// slowest tracker and largest gain: a full swing hits both pcm rails
		add_write(adcb_pkg::REG_DC_RATE_SHIFT, 16'd15);
		add_write(adcb_pkg::REG_GAIN_SHIFT, 16'd15);
		add_sample(32'h8000_0000, 1'b1, 16'h8000);
		add_sample(32'h7FFF_FFFF, 1'b1, 16'h7FFF);
		// zero frame length acts as one sample per packet
		add_write(adcb_pkg::REG_PKT_SAMPLES, 16'd0);
		add_sample(32'h0000_0000, 1'b0, 16'h0);
		// widest input shift, no gain
		add_write(adcb_pkg::REG_INPUT_SHIFT, 16'd31);
		add_write(adcb_pkg::REG_GAIN_SHIFT, 16'd0);
		add_sample(32'hFFFF_FFFF, 1'b0, 16'h0);
		// longest frame, then a frame cut short under an open packet
		add_write(adcb_pkg::REG_PKT_SAMPLES, 16'd1023);
		add_write(adcb_pkg::REG_INPUT_SHIFT, 16'd12);
		add_write(adcb_pkg::REG_GAIN_SHIFT, 16'd3);
		add_sample(32'h0123_4567, 1'b0, 16'h0);
		add_sample(32'hFEDC_BA98, 1'b0, 16'h0);
		add_sample(32'h5555_AAAA, 1'b0, 16'h0);
		add_write(adcb_pkg::REG_PKT_SAMPLES, 16'd2);
		add_sample(32'hAAAA_5555, 1'b0, 16'h0);
		// write to an unmapped index, then reset values with junk in the upper bits
		add_write(REG_UNMAPPED, 16'hFFFF);
		add_write(adcb_pkg::REG_INPUT_SHIFT, 16'hFFEF);
		add_write(adcb_pkg::REG_DC_RATE_SHIFT, 16'hFFF6);
		add_write(adcb_pkg::REG_GAIN_SHIFT, 16'hFFF5);
		add_write(adcb_pkg::REG_PKT_SAMPLES, 16'hFD40);
		add_sample(32'h0000_8000, 1'b0, 16'h0);
		add_sample(32'hFFFF_0000, 1'b0, 16'h0);
		add_sample(32'h0001_0000, 1'b0, 16'h0);

		// walk the table; the first write of a batch waits for the block to go idle
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (!writes_open) begin
					settle_idle();
					settings_run++;
				end
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				table_samples++;
				send_sample(directed_rows[i].raw, directed_rows[i].pinned, directed_rows[i].pcm);
			end
		end

		// random phases: fresh settings each time, a tone-like stream with noise mixed in
		while (random_sent < RANDOM_SAMPLES) begin
			settle_idle();
			settings_run++;
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);

			write_reg(adcb_pkg::REG_INPUT_SHIFT, with_junk(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 31) : $urandom_range(10, 20), 5));
			write_reg(adcb_pkg::REG_DC_RATE_SHIFT, with_junk($urandom_range(0, 15), 4));
			write_reg(adcb_pkg::REG_GAIN_SHIFT, with_junk($urandom_range(0, 15), 4));
			// mostly short frames so headers come often; zero and the longest now and then
			case ($urandom_range(0, 9))
				0: write_reg(adcb_pkg::REG_PKT_SAMPLES, with_junk(0, 10));
				1: write_reg(adcb_pkg::REG_PKT_SAMPLES, with_junk($urandom_range(7, 40), 10));
				2: write_reg(adcb_pkg::REG_PKT_SAMPLES, with_junk(1023, 10));
				default: write_reg(adcb_pkg::REG_PKT_SAMPLES,
					with_junk($urandom_range(1, 6), 10));
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg(IDX_W'($urandom_range(adcb_pkg::REG_PKT_SAMPLES + 1, REG_UNMAPPED)),
					DATA_W'($urandom));

			phase_len = $urandom_range(8, 40);
			offset = $signed($urandom) >>> $urandom_range(1, 24);
			scale = $urandom_range(0, 20);
			repeat (phase_len) begin
				send_sample(pick_raw(offset, scale), 1'b0, 16'h0);
				random_sent++;
			end
		end

		// drain everything and leave room for stray bytes to show up
		tx_steady = 1'b0;
		settle_idle();

		$display("ran %0d samples (%0d from the table) into %0d bytes and %0d packets",
			samples_taken, table_samples, bytes_seen, packets_opened);
		$display("%0d register writes over %0d settings, %0d errors",
			writes_seen, settings_run, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
